// ===== rtl/sfwa_pkg.sv =====
package sfwa_pkg;

   localparam int unsigned FRAME_BITS = 56;
   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned CNT_BITS   = 6;
   localparam int unsigned PADDR_BITS = 4;

   localparam logic [CNT_BITS-1:0] WREN_BITS  = 6'd8;
   localparam logic [CNT_BITS-1:0] WRITE_BITS = 6'd56;
   localparam logic [CNT_BITS-1:0] RADDR_BITS = 6'd24;
   localparam logic [CNT_BITS-1:0] RDATA_BITS = 6'd32;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] REG_OPCODE_WREN  = 2'd0;
   localparam logic [1:0] REG_OPCODE_WRITE = 2'd1;
   localparam logic [1:0] REG_OPCODE_READ  = 2'd2;

   localparam logic [7:0] OPCODE_WREN_RESET  = 8'd6;
   localparam logic [7:0] OPCODE_WRITE_RESET = 8'd2;
   localparam logic [7:0] OPCODE_READ_RESET  = 8'd3;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_WREN  = 3'd1,
      PH_GAP   = 3'd2,
      PH_WRITE = 3'd3,
      PH_RADDR = 3'd4,
      PH_RDATA = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [13:0] word_addr;
      logic [31:0] write_data;
      logic        miso;
   } req_type;

   typedef struct packed {
      logic        chip_select_n;
      logic        clock_pulse;
      logic        mosi;
      logic        busy_res;
      logic [31:0] read_word;
      logic        read_done;
      logic        request_ignored;
   } rsp_type;

   typedef struct packed {
      logic [7:0] write_enable;
      logic [7:0] write;
      logic [7:0] read;
   } opcode_type;

endpackage

// ===== rtl/sfwa_csr.sv =====
module sfwa_csr
   import sfwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output opcode_type            opcodes
);

   opcode_type  opcodes_ff;
   opcode_type  opcodes_in;
   logic        wr_en;
   logic [1:0]  reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[PADDR_BITS-1:2];
   assign wr_en     = psel & penable & pwrite;

   always_comb begin
      opcodes_in = opcodes_ff;
      if (wr_en) begin
         case (reg_index)
            REG_OPCODE_WREN:  opcodes_in.write_enable = pwdata[7:0];
            REG_OPCODE_WRITE: opcodes_in.write        = pwdata[7:0];
            REG_OPCODE_READ:  opcodes_in.read         = pwdata[7:0];
            default:          opcodes_in = opcodes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcodes_ff.write_enable <= OPCODE_WREN_RESET;
         opcodes_ff.write        <= OPCODE_WRITE_RESET;
         opcodes_ff.read         <= OPCODE_READ_RESET;
      end else begin
         opcodes_ff <= opcodes_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_OPCODE_WREN:  prdata = {24'd0, opcodes_ff.write_enable};
         REG_OPCODE_WRITE: prdata = {24'd0, opcodes_ff.write};
         REG_OPCODE_READ:  prdata = {24'd0, opcodes_ff.read};
         default:          prdata = 32'd0;
      endcase
   end

   assign opcodes = opcodes_ff;

endmodule

// ===== rtl/sfwa_engine.sv =====
module sfwa_engine
   import sfwa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  opcode_type opcodes,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   phase_type             phase_ff, phase_in, phase_a;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in, cnt_a, cnt_dec;
   logic [FRAME_BITS-1:0] tx_ff, tx_in, tx_a;
   logic [WORD_BITS-1:0]  rx_ff, rx_in, rx_a, rx_shift;
   logic [FRAME_BITS-1:0] pend_ff, pend_in, pend_a;
   logic                  ignored;
   logic [15:0]           byte_addr;
   logic                  accept;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign byte_addr = {req_data.word_addr, 2'b00};

   // start decode
   always_comb begin
      phase_a = phase_ff;
      cnt_a   = cnt_ff;
      tx_a    = tx_ff;
      rx_a    = rx_ff;
      pend_a  = pend_ff;
      ignored = 1'b0;
      if (req_data.cmd == CMD_WRITE || req_data.cmd == CMD_READ) begin
         if (phase_ff != PH_IDLE) begin
            ignored = 1'b1;
         end else if (req_data.cmd == CMD_WRITE) begin
            tx_a    = {opcodes.write_enable, 48'd0};
            pend_a  = {opcodes.write, byte_addr, req_data.write_data};
            cnt_a   = WREN_BITS;
            phase_a = PH_WREN;
         end else begin
            tx_a    = {opcodes.read, byte_addr, 32'd0};
            rx_a    = '0;
            cnt_a   = RADDR_BITS;
            phase_a = PH_RADDR;
         end
      end
   end

   assign cnt_dec  = (cnt_a != '0) ? cnt_a - 6'd1 : '0;
   assign rx_shift = {rx_a[WORD_BITS-2:0], req_data.miso};

   always_comb begin
      phase_in = phase_a;
      case (phase_a)
         PH_WREN: begin
            if (cnt_dec == '0) phase_in = PH_GAP;
         end
         PH_WRITE: begin
            if (cnt_dec == '0) phase_in = PH_IDLE;
         end
         PH_RADDR: begin
            if (cnt_dec == '0) phase_in = PH_RDATA;
         end
         PH_GAP: begin
            phase_in = PH_WRITE;
         end
         PH_RDATA: begin
            if (cnt_dec == '0) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_a;
      tx_in   = tx_a;
      rx_in   = rx_a;
      pend_in = pend_a;
      rsp_in  = '0;
      rsp_in.chip_select_n   = 1'b1;
      rsp_in.request_ignored = ignored;
      case (phase_a)
         PH_WREN, PH_WRITE, PH_RADDR: begin
            rsp_in.chip_select_n = 1'b0;
            rsp_in.clock_pulse   = 1'b1;
            rsp_in.busy_res      = 1'b1;
            rsp_in.mosi          = tx_a[FRAME_BITS-1];
            tx_in                = {tx_a[FRAME_BITS-2:0], 1'b0};
            cnt_in               = cnt_dec;
            if (phase_a == PH_RADDR && cnt_dec == '0) cnt_in = RDATA_BITS;
         end
         PH_GAP: begin
            rsp_in.busy_res = 1'b1;
            tx_in           = pend_a;
            cnt_in          = WRITE_BITS;
         end
         PH_RDATA: begin
            rsp_in.chip_select_n = 1'b0;
            rsp_in.clock_pulse   = 1'b1;
            rsp_in.busy_res      = 1'b1;
            rx_in                = rx_shift;
            cnt_in               = cnt_dec;
            if (cnt_dec == '0) begin
               rsp_in.read_word = rx_shift;
               rsp_in.read_done = 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_a;
         end
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            tx_ff    <= tx_in;
            rx_ff    <= rx_in;
            pend_ff  <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/spi_fram_word_access.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_data  (req_type: one serial tick or start)
// rsp       out        rsp_valid/rsp_ready  rsp_data  (rsp_type: pin levels, read word)
// csr       in         psel/penable/pready  paddr, pwdata, prdata (three opcode bytes)
//
// One transfer a cycle: each req item gives one rsp item, registered in the cycle after it is taken.
// Rate is set by the single result register; req_ready holds high unless rsp stalls.
// A write spans 65 ticks, a read 56 ticks; a start request while busy is flagged.
// Synchronous reset clears the sequencer and restores the opcode defaults.
module spi_fram_word_access
   import sfwa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   opcode_type opcodes;

   sfwa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .opcodes (opcodes)
   );

   sfwa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .opcodes   (opcodes),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/spi_fram_word_access_test.sv =====
module spi_fram_word_access_test;
   import sfwa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 300;
   localparam int RECONFIG_ITEMS = 100;
   localparam int HOLD_OFF       = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // predicted sequencer state and opcode registers
   logic [7:0]               op_wren  = OPCODE_WREN_RESET;
   logic [7:0]               op_write = OPCODE_WRITE_RESET;
   logic [7:0]               op_read  = OPCODE_READ_RESET;
   phase_type                fram_phase   = PH_IDLE;
   logic [CNT_BITS-1:0]      bits_left    = '0;
   logic [FRAME_BITS-1:0]    tx_frame     = '0;
   logic [WORD_BITS-1:0]     rx_word      = '0;
   logic [FRAME_BITS-1:0]    queued_frame = '0;

   rsp_type expected_pins[$];
   int      pin_errors = 0;
   int      items_sent = 0;
   int      idle_cycles = 0;
   int      hold_off_len = 0;
   bit      gaps_on;
   bit      stalls_on;

   spi_fram_word_access i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 clock = ~clock;

   function automatic rsp_type fram_tick(input req_type t);
      rsp_type     r;
      logic [15:0] byte_addr;
      r = '0;
      r.chip_select_n = 1'b1;
      byte_addr = {t.word_addr, 2'b00};
      if (t.cmd == CMD_WRITE || t.cmd == CMD_READ) begin
         if (fram_phase != PH_IDLE) begin
            r.request_ignored = 1'b1;
         end else if (t.cmd == CMD_WRITE) begin
            tx_frame     = {op_wren, 48'd0};
            queued_frame = {op_write, byte_addr, t.write_data};
            bits_left    = WREN_BITS;
            fram_phase   = PH_WREN;
         end else begin
            tx_frame   = {op_read, byte_addr, 32'd0};
            rx_word    = '0;
            bits_left  = RADDR_BITS;
            fram_phase = PH_RADDR;
         end
      end
      case (fram_phase)
         PH_WREN, PH_WRITE, PH_RADDR: begin
            r.chip_select_n = 1'b0;
            r.clock_pulse   = 1'b1;
            r.busy_res      = 1'b1;
            r.mosi          = tx_frame[FRAME_BITS-1];
            tx_frame        = {tx_frame[FRAME_BITS-2:0], 1'b0};
            if (bits_left != 0) bits_left = bits_left - 1'b1;
            if (bits_left == 0) begin
               if (fram_phase == PH_WREN) begin
                  fram_phase = PH_GAP;
               end else if (fram_phase == PH_RADDR) begin
                  bits_left  = RDATA_BITS;
                  fram_phase = PH_RDATA;
               end else begin
                  fram_phase = PH_IDLE;
               end
            end
         end
         PH_GAP: begin
            r.busy_res = 1'b1;
            tx_frame   = queued_frame;
            bits_left  = WRITE_BITS;
            fram_phase = PH_WRITE;
         end
         PH_RDATA: begin
            r.chip_select_n = 1'b0;
            r.clock_pulse   = 1'b1;
            r.busy_res      = 1'b1;
            rx_word         = {rx_word[WORD_BITS-2:0], t.miso};
            if (bits_left != 0) bits_left = bits_left - 1'b1;
            if (bits_left == 0) begin
               r.read_word = rx_word;
               r.read_done = 1'b1;
               fram_phase  = PH_IDLE;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic string pins_text(input rsp_type p);
      return $sformatf("cs_n=%b sck=%b mosi=%b busy=%b word=%h done=%b ignored=%b",
                       p.chip_select_n, p.clock_pulse, p.mosi, p.busy_res,
                       p.read_word, p.read_done, p.request_ignored);
   endfunction

   task automatic report_mismatch(input string what);
      pin_errors++;
      if (pin_errors <= 10) $display("%0t mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : pin_checker
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_pins.push_back(fram_tick(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               report_mismatch({"unexpected transfer ", pins_text(rsp_data)});
            end else begin
               want = expected_pins.pop_front();
               if (want.chip_select_n !== rsp_data.chip_select_n ||
                   want.clock_pulse !== rsp_data.clock_pulse ||
                   want.mosi !== rsp_data.mosi ||
                   want.busy_res !== rsp_data.busy_res ||
                   want.read_word !== rsp_data.read_word ||
                   want.read_done !== rsp_data.read_done ||
                   want.request_ignored !== rsp_data.request_ignored) begin
                  report_mismatch({"expected ", pins_text(want), " got ", pins_text(rsp_data)});
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("spi_fram_word_access_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_len) @(negedge clock);
            hold_off_len = 0;
            rsp_ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input req_type item);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_pins.size() != 0);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_OPCODE_WREN:  op_wren  = value;
         REG_OPCODE_WRITE: op_write = value;
         REG_OPCODE_READ:  op_read  = value;
         default: begin
         end
      endcase
   endtask

   task automatic csr_read_check(input logic [1:0] idx, input logic [7:0] value);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got[7:0] !== value)
         report_mismatch($sformatf("register %0d expected %h got %h", idx, value, got[7:0]));
   endtask

   task automatic apply_opcodes(input logic [7:0] wren, input logic [7:0] wr,
                                input logic [7:0] rd);
      wait_drained();
      csr_write(REG_OPCODE_WREN, wren);
      csr_write(REG_OPCODE_WRITE, wr);
      csr_write(REG_OPCODE_READ, rd);
      csr_read_check(REG_OPCODE_WREN, wren);
      csr_read_check(REG_OPCODE_WRITE, wr);
      csr_read_check(REG_OPCODE_READ, rd);
   endtask

   function automatic req_type random_item(input logic [1:0] cmd);
      req_type item;
      item.cmd        = cmd;
      item.word_addr  = 14'($urandom_range(0, 16383));
      item.write_data = $urandom;
      item.miso       = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // start a transfer and tick it through to idle; noise puts requests on busy ticks
   task automatic run_transfer(input req_type start, input int noise_pct,
                               input bit fixed_miso, input logic miso_level);
      req_type item;
      send_item(start);
      while (fram_phase != PH_IDLE) begin
         item = random_item(CMD_TICK);
         if (fixed_miso) item.miso = miso_level;
         if ($urandom_range(1, 100) <= noise_pct) begin
            case ($urandom_range(0, 2))
               0: item.cmd = CMD_WRITE;
               1: item.cmd = CMD_READ;
               default: item.cmd = CMD_UNUSED;
            endcase
         end
         send_item(item);
      end
   endtask

   task automatic test_register_defaults;
      csr_read_check(REG_OPCODE_WREN, OPCODE_WREN_RESET);
      csr_read_check(REG_OPCODE_WRITE, OPCODE_WRITE_RESET);
      csr_read_check(REG_OPCODE_READ, OPCODE_READ_RESET);
   endtask

   task automatic test_directed_transfers;
      req_type item;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      item = '0;
      item.cmd = CMD_TICK;
      send_item(item);
      item.cmd = CMD_UNUSED;
      send_item(item);
      item = '0;
      item.cmd = CMD_WRITE;
      run_transfer(item, 0, 1'b1, 1'b0);
      item.word_addr  = '1;
      item.write_data = '1;
      item.miso       = 1'b1;
      run_transfer(item, 0, 1'b1, 1'b1);
      item = '0;
      item.cmd = CMD_READ;
      run_transfer(item, 0, 1'b1, 1'b0);
      item.word_addr = '1;
      run_transfer(item, 0, 1'b1, 1'b1);
      run_transfer(random_item(CMD_WRITE), 100, 1'b0, 1'b0);
      run_transfer(random_item(CMD_READ), 100, 1'b0, 1'b0);
      item = random_item(CMD_TICK);
      send_item(item);
      wait_drained();
   endtask

   task automatic test_opcode_settings;
      logic [7:0] setting [0:3][0:2];
      setting[0] = '{8'h00, 8'h00, 8'h00};
      setting[1] = '{8'hFF, 8'hFF, 8'hFF};
      setting[2] = '{8'hA5, 8'h5A, 8'h81};
      setting[3] = '{8'($urandom), 8'($urandom), 8'($urandom)};
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      for (int s = 0; s < 4; s++) begin
         apply_opcodes(setting[s][0], setting[s][1], setting[s][2]);
         run_transfer(random_item(CMD_WRITE), 0, 1'b0, 1'b0);
         run_transfer(random_item(CMD_READ), 0, 1'b0, 1'b0);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic;
      int      first;
      int      next_reconfig;
      int      pick;
      req_type item;
      first = items_sent;
      next_reconfig = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         if (items_sent >= next_reconfig) begin
            case ($urandom_range(0, 3))
               0: apply_opcodes(8'h00, 8'hFF, 8'h00);
               1: apply_opcodes(8'hFF, 8'h00, 8'hFF);
               default: apply_opcodes(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            next_reconfig = items_sent + RECONFIG_ITEMS;
         end
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            run_transfer(random_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ),
                         5, 1'b0, 1'b0);
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4))
               send_item(random_item($urandom_range(0, 1) ? CMD_TICK : CMD_UNUSED));
         end else begin
            repeat ($urandom_range(1, 20)) send_item(random_item(2'($urandom_range(0, 3))));
            while (fram_phase != PH_IDLE) send_item(random_item(CMD_TICK));
         end
      end
      wait_drained();
   endtask

   task automatic test_receiver_hold_off;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      hold_off_len = HOLD_OFF;
      run_transfer(random_item(CMD_WRITE), 5, 1'b0, 1'b0);
      run_transfer(random_item(CMD_READ), 5, 1'b0, 1'b0);
      wait_drained();
   endtask

   task automatic test_unthrottled_tail;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      apply_opcodes(8'($urandom), 8'($urandom), 8'($urandom));
      repeat (3)
         run_transfer(random_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ),
                      10, 1'b0, 1'b0);
      wait_drained();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_defaults();
      test_directed_transfers();
      test_opcode_settings();
      test_random_traffic();
      test_receiver_hold_off();
      test_unthrottled_tail();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pin_errors == 0 && expected_pins.size() == 0) begin
         $display("spi_fram_word_access_test passed");
      end else begin
         $display("spi_fram_word_access_test failed");
      end
      $finish;
   end

endmodule
